@@ rtl/olv_pkg.sv @@
// shared types and constants of the ordered value list engine
package olv_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int MAX_RESULTS  = 64;
    localparam int VAL_W        = 32;
    localparam int POS_W        = 6;
    localparam int CNT_W        = 7;
    localparam int MATCH_W      = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_SEARCH = 2'd1,
        ACT_UPDATE = 2'd2,
        ACT_DELETE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_SH_RD,
        S_SH_WR,
        S_FIN
    } t_state;

    typedef struct packed {
        logic              last;
        logic [CNT_W-1:0]  count;
        logic [POS_W-1:0]  pos;
        t_status           status;
    } t_result;

endpackage

@@ rtl/olv_ram.sv @@
// generic single write port, single read port ram with registered read
module olv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/olv_ctrl.sv @@
// command sequencer with the shared compare unit, walks the stored entries
module olv_ctrl #(
    parameter int CAPACITY = olv_pkg::CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  olv_pkg::t_action            i_action,
    input  logic [olv_pkg::VAL_W-1:0]   i_key,
    input  logic [olv_pkg::VAL_W-1:0]   i_repl,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output olv_pkg::t_result            o_res,
    output logic                        o_we,
    output logic [$clog2(CAPACITY)-1:0] o_waddr,
    output logic [olv_pkg::VAL_W-1:0]   o_wdata,
    output logic [$clog2(CAPACITY)-1:0] o_raddr,
    input  logic [olv_pkg::VAL_W-1:0]   i_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = olv_pkg::MATCH_W;
    localparam int PW = olv_pkg::POS_W;
    localparam int NW = olv_pkg::CNT_W;

    olv_pkg::t_state  r_state, n_state;
    olv_pkg::t_action r_act, n_act;
    olv_pkg::t_status r_status, n_status;
    logic [CW-1:0]    r_occ, n_occ;
    logic [AW-1:0]    r_idx, n_idx;
    logic [AW-1:0]    r_pend, n_pend;
    logic [MW-1:0]    r_nmatch, n_nmatch;
    logic [olv_pkg::VAL_W-1:0] r_key, n_key;
    logic [olv_pkg::VAL_W-1:0] r_repl, n_repl;

    logic match;
    logic last_idx;
    logic shift_end;

    assign match     = (i_rdata == r_key);
    assign last_idx  = ((CW'(r_idx) + CW'(1)) == r_occ);
    assign shift_end = ((CW'(r_idx) + CW'(2)) == r_occ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= olv_pkg::S_IDLE;
            r_occ   <= '0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_status <= n_status;
        r_idx    <= n_idx;
        r_pend   <= n_pend;
        r_nmatch <= n_nmatch;
        r_key    <= n_key;
        r_repl   <= n_repl;
    end

    always_comb begin
        n_state  = r_state;
        n_act    = r_act;
        n_status = r_status;
        n_occ    = r_occ;
        n_idx    = r_idx;
        n_pend   = r_pend;
        n_nmatch = r_nmatch;
        n_key    = r_key;
        n_repl   = r_repl;

        o_ready      = 1'b0;
        o_we         = 1'b0;
        o_waddr      = r_idx;
        o_wdata      = i_rdata;
        o_raddr      = r_idx;
        o_res_valid  = 1'b0;
        o_res.status = r_status;
        o_res.pos    = '0;
        o_res.count  = NW'(r_occ);
        o_res.last   = 1'b1;

        case (r_state)
            olv_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_act    = i_action;
                    n_key    = i_key;
                    n_repl   = i_repl;
                    n_idx    = '0;
                    n_nmatch = '0;
                    if (i_action == olv_pkg::ACT_INSERT) begin
                        n_state = olv_pkg::S_FIN;
                        if (r_occ == CW'(CAPACITY)) begin
                            n_status = olv_pkg::ST_FULL;
                        end else begin
                            o_we     = 1'b1;
                            o_waddr  = r_occ[AW-1:0];
                            o_wdata  = i_key;
                            n_occ    = r_occ + CW'(1);
                            n_status = olv_pkg::ST_OK;
                        end
                    end else if (r_occ == '0) begin
                        n_status = olv_pkg::ST_EMPTY;
                        n_state  = olv_pkg::S_FIN;
                    end else begin
                        n_status = olv_pkg::ST_NOTFOUND;
                        n_state  = olv_pkg::S_RD;
                    end
                end
            end

            olv_pkg::S_RD: begin
                n_state = olv_pkg::S_CMP;
            end

            olv_pkg::S_CMP: begin
                case (r_act)
                    olv_pkg::ACT_SEARCH: begin
                        if (match) begin
                            // an earlier match goes out now, it is not the final one
                            o_res_valid = (r_status == olv_pkg::ST_OK);
                            o_res.pos   = PW'(r_pend);
                            o_res.last  = 1'b0;
                            if (r_status != olv_pkg::ST_OK || i_res_ready) begin
                                n_status = olv_pkg::ST_OK;
                                n_pend   = r_idx;
                                n_nmatch = r_nmatch + MW'(1);
                                if (last_idx
                                    || (r_nmatch + MW'(1)) == MW'(olv_pkg::MAX_RESULTS)) begin
                                    n_state = olv_pkg::S_FIN;
                                end else begin
                                    n_idx   = r_idx + AW'(1);
                                    n_state = olv_pkg::S_RD;
                                end
                            end
                        end else if (last_idx) begin
                            n_state = olv_pkg::S_FIN;
                        end else begin
                            n_idx   = r_idx + AW'(1);
                            n_state = olv_pkg::S_RD;
                        end
                    end
                    olv_pkg::ACT_UPDATE: begin
                        if (match) begin
                            o_we     = 1'b1;
                            o_wdata  = r_repl;
                            n_status = olv_pkg::ST_OK;
                        end
                        if (last_idx) begin
                            n_state = olv_pkg::S_FIN;
                        end else begin
                            n_idx   = r_idx + AW'(1);
                            n_state = olv_pkg::S_RD;
                        end
                    end
                    default: begin
                        if (match) begin
                            n_status = olv_pkg::ST_OK;
                            if (last_idx) begin
                                n_occ   = r_occ - CW'(1);
                                n_state = olv_pkg::S_FIN;
                            end else begin
                                n_state = olv_pkg::S_SH_RD;
                            end
                        end else if (last_idx) begin
                            n_state = olv_pkg::S_FIN;
                        end else begin
                            n_idx   = r_idx + AW'(1);
                            n_state = olv_pkg::S_RD;
                        end
                    end
                endcase
            end

            // close the gap: entry idx+1 moves down to idx
            olv_pkg::S_SH_RD: begin
                o_raddr = r_idx + AW'(1);
                n_state = olv_pkg::S_SH_WR;
            end

            olv_pkg::S_SH_WR: begin
                o_raddr = r_idx + AW'(1);
                o_we    = 1'b1;
                if (shift_end) begin
                    n_occ   = r_occ - CW'(1);
                    n_state = olv_pkg::S_FIN;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = olv_pkg::S_SH_RD;
                end
            end

            olv_pkg::S_FIN: begin
                o_res_valid = 1'b1;
                if (r_act == olv_pkg::ACT_SEARCH && r_status == olv_pkg::ST_OK) begin
                    o_res.pos = PW'(r_pend);
                end
                if (i_res_ready) begin
                    n_state = olv_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = olv_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/ordered_value_list_engine.sv @@
// top level of the ordered value list engine: ports, output register, value store
//
// channel   direction  tdata                                    tuser    tlast
// s_axis    in         [31:0] key_value, [63:32] replacement    action   -
// m_axis    out        [1:0] status, [7:2] position,            -        last
//                      [14:8] entry_count
//
// insert, and any command on an empty list: straight to the result state
// search, update: read and compare per stored entry to the scan end, then result
// delete: read, compare per entry to the match, shift read and write per entry
// behind it, then result; the single read port of the value store (registered
// read) and the one comparator set these steps; a later search match waits while
// the output is full; reset clears count, state, output valid, not stored values
module ordered_value_list_engine #(
    parameter int CAPACITY = olv_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // key_value, replacement_value
    input  logic [1:0]  i_s_axis_tuser,   // action
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // status, position, entry_count, pad
    output logic        o_m_axis_tlast
);

    localparam int AW = $clog2(CAPACITY);
    localparam int VW = olv_pkg::VAL_W;

    logic             res_valid;
    logic             res_ready;
    olv_pkg::t_result res;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;
    logic [VW-1:0]    wdata;
    logic [VW-1:0]    rdata;

    logic             r_ov;
    olv_pkg::t_result r_out;

    olv_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_action    (olv_pkg::t_action'(i_s_axis_tuser)),
        .i_key       (i_s_axis_tdata[VW-1:0]),
        .i_repl      (i_s_axis_tdata[2*VW-1:VW]),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    olv_ram #(
        .WIDTH(VW),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // output register takes a new result when empty or emptied by this transfer
    assign res_ready = !r_ov || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_ov <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {1'b0, r_out.count, r_out.pos, r_out.status};
    assign o_m_axis_tlast  = r_out.last;

endmodule

@@ rtl/olv_checker.sv @@
// port level checks of the ordered value list engine, bound to the top level
module olv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tready,
    input logic        i_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] i_m_axis_tdata,
    input logic        i_m_axis_tlast
);

    // output register is empty right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_axis_tvalid)
        else $error("result shown right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=>
            i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tlast))
        else $error("stalled result changed");

    // only a search match may carry a position or leave the command open
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && i_m_axis_tdata[1:0] != olv_pkg::ST_OK |->
            i_m_axis_tlast && i_m_axis_tdata[7:2] == '0)
        else $error("failure result not final or with position");

    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && i_m_axis_tdata[1:0] == olv_pkg::ST_EMPTY |->
            i_m_axis_tdata[14:8] == '0)
        else $error("empty status with entries");

    // while a command still has results to give, no new command is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tlast |-> !i_s_axis_tready)
        else $error("command taken while search results pending");

endmodule

bind ordered_value_list_engine olv_checker u_olv_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tlast  (o_m_axis_tlast)
);
